// ===== design/bbe_pkg.sv =====
// shared constants, types and the reciprocal table of the box blur unit
package bbe_pkg;

  // frame limits and the widths that follow from them
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // configuration register widths and codes
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

  // request kinds on the input tuser bit
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // pixel and line store layout
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int LANES  = 3;
  localparam int LANE_IDX_W = 2;
  localparam int STORE_W = LANES * PIX_W;

  // averaging arithmetic
  localparam int SUM_W   = 12;
  localparam int CSUM_W  = 10;
  localparam int CNT_W   = 4;
  localparam int NUM_W   = 13;
  localparam int RECIP_W = 24;
  localparam int RECIP_SH = 24;
  localparam int PROD_W  = NUM_W + RECIP_W;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OUT_W      = PIX_W + 1;

  // one column of the window, rows above, at and below the output row
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] dn;
  } pix_col_t;

  // window sums handed from the window stage to the divide stage
  typedef struct packed {
    logic                       v;
    logic                       fe;
    logic [CNT_W-1:0]           cnt;
    logic [2:0][SUM_W-1:0]      sum;
  } sum_t;

  // ceil(2^24 / (2 * count)) for counts 1 to 9
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 24'd8388608;
      4'd2:    r = 24'd4194304;
      4'd3:    r = 24'd2796203;
      4'd4:    r = 24'd2097152;
      4'd5:    r = 24'd1677722;
      4'd6:    r = 24'd1398102;
      4'd7:    r = 24'd1198373;
      4'd8:    r = 24'd1048576;
      4'd9:    r = 24'd932068;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/bbe_ram.sv =====
// generic ram, one lane-masked write port, two registered read ports
module bbe_ram #(
  parameter int WIDTH  = 72,
  parameter int DEPTH  = 1024,
  parameter int LANE_W = 24
) (
  input  logic                       clk,
  input  logic [WIDTH/LANE_W-1:0]    we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   ra_addr,
  input  logic [$clog2(DEPTH)-1:0]   rb_addr,
  output logic [WIDTH-1:0]           qa,
  output logic [WIDTH-1:0]           qb
);

  localparam int NL = WIDTH / LANE_W;

  logic [WIDTH-1:0] mem [DEPTH];

  // lane writes, reads return the old word on a same-address write
  always_ff @(posedge clk) begin
    for (int k = 0; k < NL; k++) begin
      if (we[k]) begin
        mem[waddr][k*LANE_W +: LANE_W] <= wdata[k*LANE_W +: LANE_W];
      end
    end
    qa <= mem[ra_addr];
    qb <= mem[rb_addr];
  end

endmodule

// ===== design/bbe_track.sv =====
// input and emit position tracking, line store writes and result credits
module bbe_track (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_fire,
  input  logic                              req_type,
  input  logic [bbe_pkg::PIX_W-1:0]         pix,
  input  logic                              issue,
  output logic                              s_tready,
  output logic                              cred_nz,
  output logic                              restart,
  output logic [bbe_pkg::WID_W-1:0]         w_eff,
  output logic [bbe_pkg::HGT_W-1:0]         h_eff,
  output logic [bbe_pkg::LANES-1:0]         wr_lane,
  output logic [bbe_pkg::COL_W-1:0]         wr_addr,
  output logic [bbe_pkg::STORE_W-1:0]       wr_data
);

  typedef struct packed {
    logic [bbe_pkg::ROW_W-1:0] ir;
    logic [bbe_pkg::COL_W-1:0] ic;
    logic [bbe_pkg::ROW_W-1:0] orow;
    logic [bbe_pkg::COL_W-1:0] ocol;
    logic                      done;
  } trk_t;

  logic [bbe_pkg::WID_W-1:0]      frame_width;
  logic [bbe_pkg::HGT_W-1:0]      frame_height;
  trk_t                           st, st0, st1, st2;
  logic [1:0]                     cred, cred_next;
  logic [bbe_pkg::LANE_IDX_W-1:0] lane, lane_next;
  logic                           pix_ok, flush, e0, e1;

  // next output window fully received
  function automatic logic ready(input trk_t s, input logic [bbe_pkg::WID_W-1:0] w,
                                 input logic [bbe_pkg::HGT_W-1:0] h);
    logic [bbe_pkg::HGT_W-1:0] r1, nr;
    logic [bbe_pkg::WID_W-1:0] c1, nc;
    r1 = bbe_pkg::HGT_W'(s.orow) + bbe_pkg::HGT_W'(1);
    c1 = bbe_pkg::WID_W'(s.ocol) + bbe_pkg::WID_W'(1);
    nr = (r1 < h) ? r1 : h - bbe_pkg::HGT_W'(1);
    nc = (c1 < w) ? c1 : w - bbe_pkg::WID_W'(1);
    return s.done || (nr < bbe_pkg::HGT_W'(s.ir)) ||
           ((nr == bbe_pkg::HGT_W'(s.ir)) && (nc < bbe_pkg::WID_W'(s.ic)));
  endfunction

  // step the emit position, the frame's last output restarts everything
  function automatic trk_t advance(input trk_t s, input logic [bbe_pkg::WID_W-1:0] w,
                                   input logic [bbe_pkg::HGT_W-1:0] h);
    trk_t                      t;
    logic [bbe_pkg::HGT_W-1:0] r1;
    logic [bbe_pkg::WID_W-1:0] c1;
    t  = s;
    r1 = bbe_pkg::HGT_W'(s.orow) + bbe_pkg::HGT_W'(1);
    c1 = bbe_pkg::WID_W'(s.ocol) + bbe_pkg::WID_W'(1);
    if (c1 >= w) begin
      t.ocol = '0;
      if (r1 >= h) begin
        t = '0;
      end else begin
        t.orow = r1[bbe_pkg::ROW_W-1:0];
      end
    end else begin
      t.ocol = c1[bbe_pkg::COL_W-1:0];
    end
    return t;
  endfunction

  // step the input position
  function automatic trk_t take(input trk_t s, input logic [bbe_pkg::WID_W-1:0] w,
                                input logic [bbe_pkg::HGT_W-1:0] h);
    trk_t                      t;
    logic [bbe_pkg::HGT_W-1:0] r1;
    logic [bbe_pkg::WID_W-1:0] c1;
    t  = s;
    r1 = bbe_pkg::HGT_W'(s.ir) + bbe_pkg::HGT_W'(1);
    c1 = bbe_pkg::WID_W'(s.ic) + bbe_pkg::WID_W'(1);
    if (c1 >= w) begin
      t.ic = '0;
      if (r1 >= h) begin
        t.ir   = '0;
        t.done = 1'b1;
      end else begin
        t.ir = r1[bbe_pkg::ROW_W-1:0];
      end
    end else begin
      t.ic = c1[bbe_pkg::COL_W-1:0];
    end
    return t;
  endfunction

  // clamp the frame size to the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_eff = bbe_pkg::WID_W'(1);
    end else if (frame_width > bbe_pkg::WID_W'(bbe_pkg::MAX_WIDTH)) begin
      w_eff = bbe_pkg::WID_W'(bbe_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = bbe_pkg::HGT_W'(1);
    end else if (frame_height > bbe_pkg::HGT_W'(bbe_pkg::MAX_HEIGHT)) begin
      h_eff = bbe_pkg::HGT_W'(bbe_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // results caused by this word: up to two emits after the pixel lands
  always_comb begin
    pix_ok = s_fire && (req_type == bbe_pkg::REQ_PIXEL) && !st.done;
    flush  = s_fire && (req_type == bbe_pkg::REQ_FLUSH);
    st0    = pix_ok ? take(st, w_eff, h_eff) : st;
    e0     = ready(st0, w_eff, h_eff) &&
             (pix_ok || (flush && (st.done || (st.ir != '0) || (st.ic != '0))));
    st1    = e0 ? advance(st0, w_eff, h_eff) : st0;
    e1     = pix_ok && e0 && ready(st1, w_eff, h_eff);
    st2    = e1 ? advance(st1, w_eff, h_eff) : st1;
  end

  // row lane of the line store follows the input row modulo three
  always_comb begin
    lane_next = lane;
    if (pix_ok && (st0.ir != st.ir)) begin
      if (st0.ir == '0) begin
        lane_next = '0;
      end else begin
        lane_next = (lane == 2'd2) ? 2'd0 : lane + 2'd1;
      end
    end
  end

  // pending results not yet started by the window stage
  assign cred_next = 2'(cred - {1'b0, issue} + {1'b0, e0} + {1'b0, e1});
  assign cred_nz   = (cred != 2'd0);
  assign s_tready  = (cred == 2'd0) || ((cred == 2'd1) && issue);
  assign restart   = cfg_valid && ((cfg_index == bbe_pkg::REG_WIDTH) ||
                                   (cfg_index == bbe_pkg::REG_HEIGHT));

  // line store write of the accepted pixel
  assign wr_addr = st.ic;
  assign wr_data = {bbe_pkg::LANES{pix}};
  always_comb begin
    wr_lane = '0;
    if (pix_ok) begin
      case (lane)
        2'd0:    wr_lane = 3'b001;
        2'd1:    wr_lane = 3'b010;
        2'd2:    wr_lane = 3'b100;
        default: wr_lane = '0;
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbe_pkg::WIDTH_RESET;
      frame_height <= bbe_pkg::HEIGHT_RESET;
      st           <= '0;
      cred         <= '0;
      lane         <= '0;
    end else if (restart) begin
      if (cfg_index == bbe_pkg::REG_WIDTH) begin
        frame_width <= cfg_data[bbe_pkg::WID_W-1:0];
      end else begin
        frame_height <= cfg_data[bbe_pkg::HGT_W-1:0];
      end
      st   <= '0;
      lane <= '0;
    end else begin
      st   <= st2;
      cred <= cred_next;
      lane <= lane_next;
    end
  end

endmodule

// ===== design/bbe_window.sv =====
// output position, column reads from the line store and window sums
module bbe_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [bbe_pkg::WID_W-1:0]     w_eff,
  input  logic [bbe_pkg::HGT_W-1:0]     h_eff,
  input  logic                          cred_nz,
  input  logic                          room,
  input  logic [bbe_pkg::STORE_W-1:0]   qa,
  input  logic [bbe_pkg::STORE_W-1:0]   qb,
  output logic                          issue,
  output logic [bbe_pkg::COL_W-1:0]     ra_addr,
  output logic [bbe_pkg::COL_W-1:0]     rb_addr,
  output logic [1:0]                    infl,
  output bbe_pkg::sum_t                 s2
);

  typedef struct packed {
    logic                           v;
    logic                           first;
    logic                           has_r;
    logic                           has_u;
    logic                           has_d;
    logic                           fe;
    logic [bbe_pkg::LANE_IDX_W-1:0] lu;
    logic [bbe_pkg::LANE_IDX_W-1:0] lm;
    logic [bbe_pkg::LANE_IDX_W-1:0] ld;
  } s1_t;

  logic [bbe_pkg::ROW_W-1:0]      gr;
  logic [bbe_pkg::COL_W-1:0]      gc;
  logic [bbe_pkg::LANE_IDX_W-1:0] glane;
  logic [bbe_pkg::HGT_W-1:0]      r1;
  logic [bbe_pkg::WID_W-1:0]      c1;
  logic                           last_col, last_row;
  s1_t                            s1;
  bbe_pkg::pix_col_t              col_l, col_m, col_r, mid_reg, right_reg;
  bbe_pkg::sum_t                  s2_next;
  logic [1:0]                     nrows, ncols;

  function automatic logic [bbe_pkg::PIX_W-1:0] pick(
      input logic [bbe_pkg::STORE_W-1:0] q, input logic [bbe_pkg::LANE_IDX_W-1:0] l);
    logic [bbe_pkg::PIX_W-1:0] p;
    case (l)
      2'd0:    p = q[0*bbe_pkg::PIX_W +: bbe_pkg::PIX_W];
      2'd1:    p = q[1*bbe_pkg::PIX_W +: bbe_pkg::PIX_W];
      2'd2:    p = q[2*bbe_pkg::PIX_W +: bbe_pkg::PIX_W];
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [bbe_pkg::CSUM_W-1:0] colsum(
      input bbe_pkg::pix_col_t c, input int ch, input logic u, input logic d);
    logic [bbe_pkg::CSUM_W-1:0] acc;
    acc = bbe_pkg::CSUM_W'(c.mid[ch*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
    if (u) begin
      acc = acc + bbe_pkg::CSUM_W'(c.up[ch*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
    end
    if (d) begin
      acc = acc + bbe_pkg::CSUM_W'(c.dn[ch*bbe_pkg::CH_W +: bbe_pkg::CH_W]);
    end
    return acc;
  endfunction

  // start one output per cycle while results are owed and the queue has room
  assign issue    = cred_nz && room;
  assign r1       = bbe_pkg::HGT_W'(gr) + bbe_pkg::HGT_W'(1);
  assign c1       = bbe_pkg::WID_W'(gc) + bbe_pkg::WID_W'(1);
  assign last_col = (c1 >= w_eff);
  assign last_row = (r1 >= h_eff);
  assign ra_addr  = c1[bbe_pkg::COL_W-1:0];
  assign rb_addr  = gc;
  assign infl     = 2'({1'b0, s1.v} + {1'b0, s2.v});

  // output position, read stage and window shape of the issued output
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      gr    <= '0;
      gc    <= '0;
      glane <= '0;
      s1.v  <= 1'b0;
    end else begin
      s1.v <= issue;
      if (issue) begin
        if (last_col) begin
          gc <= '0;
          if (last_row) begin
            gr    <= '0;
            glane <= '0;
          end else begin
            gr    <= r1[bbe_pkg::ROW_W-1:0];
            glane <= (glane == 2'd2) ? 2'd0 : glane + 2'd1;
          end
        end else begin
          gc <= c1[bbe_pkg::COL_W-1:0];
        end
      end
    end
    if (issue) begin
      s1.first <= (gc == '0);
      s1.has_r <= !last_col;
      s1.has_u <= (gr != '0);
      s1.has_d <= !last_row;
      s1.fe    <= last_col && last_row;
      s1.lu    <= (glane == 2'd0) ? 2'd2 : glane - 2'd1;
      s1.lm    <= glane;
      s1.ld    <= (glane == 2'd2) ? 2'd0 : glane + 2'd1;
    end
  end

  // columns of the window: new right column, mid and left from earlier reads
  always_comb begin
    col_r.up  = pick(qa, s1.lu);
    col_r.mid = pick(qa, s1.lm);
    col_r.dn  = pick(qa, s1.ld);
    if (s1.first) begin
      col_m.up  = pick(qb, s1.lu);
      col_m.mid = pick(qb, s1.lm);
      col_m.dn  = pick(qb, s1.ld);
    end else begin
      col_m = right_reg;
    end
    col_l = mid_reg;
  end

  always_ff @(posedge clk) begin
    if (s1.v) begin
      mid_reg   <= col_m;
      right_reg <= col_r;
    end
  end

  // masked sums and neighbour count
  always_comb begin
    nrows = 2'(2'd1 + {1'b0, s1.has_u} + {1'b0, s1.has_d});
    ncols = 2'(2'd1 + {1'b0, !s1.first} + {1'b0, s1.has_r});
    s2_next.v   = s1.v;
    s2_next.fe  = s1.fe;
    s2_next.cnt = bbe_pkg::CNT_W'(nrows) * bbe_pkg::CNT_W'(ncols);
    for (int ch = 0; ch < 3; ch++) begin
      s2_next.sum[ch] = bbe_pkg::SUM_W'(colsum(col_m, ch, s1.has_u, s1.has_d));
      if (!s1.first) begin
        s2_next.sum[ch] = s2_next.sum[ch] +
                          bbe_pkg::SUM_W'(colsum(col_l, ch, s1.has_u, s1.has_d));
      end
      if (s1.has_r) begin
        s2_next.sum[ch] = s2_next.sum[ch] +
                          bbe_pkg::SUM_W'(colsum(col_r, ch, s1.has_u, s1.has_d));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s2.v <= 1'b0;
    end else begin
      s2.v <= s2_next.v;
    end
    s2.fe  <= s2_next.fe;
    s2.cnt <= s2_next.cnt;
    s2.sum <= s2_next.sum;
  end

endmodule

// ===== design/bbe_avg.sv =====
// rounded mean by reciprocal multiply and the result queue
module bbe_avg (
  input  logic                        clk,
  input  logic                        rst,
  input  bbe_pkg::sum_t               s2,
  input  logic [1:0]                  infl,
  output logic                        room,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bbe_pkg::PIX_W-1:0]   m_tdata,
  output logic                        m_tlast
);

  logic                                   v3, fe3;
  logic [2:0][bbe_pkg::PROD_W-1:0]        prod;
  logic [bbe_pkg::NUM_W-1:0]              num [3];
  logic [bbe_pkg::RECIP_W-1:0]            rc;
  logic [bbe_pkg::OUT_W-1:0]              fifo [bbe_pkg::FIFO_DEPTH];
  logic [bbe_pkg::FIFO_AW-1:0]            wptr, rptr;
  logic [bbe_pkg::FIFO_AW:0]              count;
  logic [bbe_pkg::OUT_W-1:0]              push_word, head;
  logic                                   pop;

  // (2*sum + count) times ceil(2^24 / (2*count))
  assign rc = bbe_pkg::recip(s2.cnt);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = bbe_pkg::NUM_W'({s2.sum[k], 1'b0}) + bbe_pkg::NUM_W'(s2.cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= s2.v;
    end
    fe3 <= s2.fe;
    for (int k = 0; k < 3; k++) begin
      prod[k] <= bbe_pkg::PROD_W'(num[k]) * bbe_pkg::PROD_W'(rc);
    end
  end

  // quotients packed red in the low byte, frame end on top
  assign push_word = {fe3,
                      prod[2][bbe_pkg::RECIP_SH +: bbe_pkg::CH_W],
                      prod[1][bbe_pkg::RECIP_SH +: bbe_pkg::CH_W],
                      prod[0][bbe_pkg::RECIP_SH +: bbe_pkg::CH_W]};

  // result queue, room counts everything already in flight
  assign pop  = m_tvalid && m_tready;
  assign room = (count + (bbe_pkg::FIFO_AW+1)'(infl) + (bbe_pkg::FIFO_AW+1)'(v3)) <
                (bbe_pkg::FIFO_AW+1)'(bbe_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (v3) begin
      fifo[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (v3) begin
        wptr <= wptr + bbe_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + bbe_pkg::FIFO_AW'(1);
      end
      count <= count + (bbe_pkg::FIFO_AW+1)'(v3) - (bbe_pkg::FIFO_AW+1)'(pop);
    end
  end

  assign head     = fifo[rptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = head[bbe_pkg::PIX_W-1:0];
  assign m_tlast  = head[bbe_pkg::PIX_W];

endmodule

// ===== design/box_blur_3x3_edge_aware_unit.sv =====
// path of a result: credit count, read stage s1, sum stage s2, product register, result queue
// throughput: one pixel word per cycle while the queue has room; a word that completes a row end causes
//   two results and holds s_tready low while both are still owed to the window stage (one ram port pair)
// the result queue holds 8 words; a stalled output backs up into s_tready
// reset: synchronous, clears positions, credits and queue; 640x480 frame size
// line store contents are not cleared, every entry is written before it is read
module box_blur_3x3_edge_aware_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bbe_pkg::PIX_W-1:0]         s_tdata,   // in_red, in_green, in_blue
  input  logic                              s_tuser,   // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bbe_pkg::PIX_W-1:0]         m_tdata,   // out_red, out_green, out_blue
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                            s_fire, issue, cred_nz, restart, room;
  logic [bbe_pkg::WID_W-1:0]       w_eff;
  logic [bbe_pkg::HGT_W-1:0]       h_eff;
  logic [bbe_pkg::LANES-1:0]       wr_lane;
  logic [bbe_pkg::COL_W-1:0]       wr_addr, ra_addr, rb_addr;
  logic [bbe_pkg::STORE_W-1:0]     wr_data, qa, qb;
  logic [1:0]                      infl;
  bbe_pkg::sum_t                   s2;

  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // position tracking and line store writes
  bbe_track u_track (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .s_fire, .req_type(s_tuser), .pix(s_tdata), .issue,
    .s_tready, .cred_nz, .restart, .w_eff, .h_eff,
    .wr_lane, .wr_addr, .wr_data
  );

  // three rows of pixels, one column per entry
  bbe_ram #(
    .WIDTH(bbe_pkg::STORE_W), .DEPTH(bbe_pkg::MAX_WIDTH), .LANE_W(bbe_pkg::PIX_W)
  ) u_store (
    .clk, .we(wr_lane), .waddr(wr_addr), .wdata(wr_data),
    .ra_addr, .rb_addr, .qa, .qb
  );

  // window reads and sums
  bbe_window u_window (
    .clk, .rst, .restart, .w_eff, .h_eff, .cred_nz, .room,
    .qa, .qb, .issue, .ra_addr, .rb_addr, .infl, .s2
  );

  // mean and result queue
  bbe_avg u_avg (
    .clk, .rst, .s2, .infl, .room, .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule

// ===== design/bbe_checker.sv =====
// port-level checks of the box blur unit and their binding
module bbe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bbe_pkg::PIX_W-1:0]      m_tdata,
  input logic                           m_tlast
);

  // nothing to deliver right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // no credits owed after reset, input open
  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind box_blur_3x3_edge_aware_unit bbe_checker u_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
